// ----- sv/slcd_pkg.sv -----
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CAP_BYTE_W = 18;
    localparam int unsigned CAP_WORD_W = 17;
    localparam int unsigned INDEX_W    = 16;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned PADDR_W    = 3;

    localparam logic [CAP_BYTE_W-1:0] CAP_BYTES_RESET = 18'd4096;

    // Register byte addresses on the configuration port.
    localparam logic [PADDR_W-1:0] ADDR_SYNC_WORD = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_CAP_BYTES = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_WAIT_SYNC = 3'd0,
        ST_WAIT_LEN  = 3'd1,
        ST_PAYLOAD   = 3'd2,
        ST_WAIT_SUM  = 3'd3,
        ST_COMPLETE  = 3'd4
    } parse_state_t;

endpackage

// ----- sv/slcd_ifs.sv -----
// ----------------------------------------------------------------------------
// slcd_ifs
// Valid/ready channels carrying mailbox words in and deframer results out.
// ----------------------------------------------------------------------------
interface slcd_in_if
    import slcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_in;

    modport source (output valid, output word_in, input ready);
    modport sink   (input valid, input word_in, output ready);
endinterface

interface slcd_out_if
    import slcd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] parse_status;
    logic                store_valid;
    logic [INDEX_W-1:0]  store_index;
    logic [WORD_W-1:0]   store_word;
    logic                checksum_error;
    logic [WORD_W-1:0]   message_bytes;

    modport source (
        output valid, output parse_status, output store_valid, output store_index,
        output store_word, output checksum_error, output message_bytes,
        input ready
    );
    modport sink (
        input valid, input parse_status, input store_valid, input store_index,
        input store_word, input checksum_error, input message_bytes,
        output ready
    );
endinterface

// ----- sv/sync_length_checksum_deframer_core.sv -----
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Deframes sync word / length / payload / checksum frames from mailbox words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  in_ch     sink       word_in
//  out_ch    source     parse_status, store_valid, store_index, store_word,
//                       checksum_error, message_bytes
//  APB       slave      sync_word (0x0), buffer_capacity_bytes (0x4)
//
// One beat in gives one beat out in the next cycle, and a beat is taken every
// cycle. The frame state and the result register are updated at the same edge.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
// Reset returns the parser to waiting for sync and restores the APB registers.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core
    import slcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    slcd_in_if.sink              in_ch,
    slcd_out_if.source           out_ch,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [WORD_W-1:0]    pwdata,
    output logic [WORD_W-1:0]    prdata,
    output logic                 pready
);

    logic [WORD_W-1:0]     sync_word_reg;
    logic [CAP_BYTE_W-1:0] cap_bytes_reg;

    parse_state_t      state_reg, state_next;
    logic [WORD_W-1:0] cursor_reg, cursor_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [WORD_W-1:0] expected_reg, expected_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                st_valid_reg, st_valid_next;
    logic [INDEX_W-1:0]  st_index_reg, st_index_next;
    logic [WORD_W-1:0]   st_word_reg, st_word_next;
    logic                err_reg, err_next;
    logic [WORD_W-1:0]   bytes_reg, bytes_next;

    logic                  cfg_write;
    logic [CAP_WORD_W-1:0] cap_words;
    logic [WORD_W-1:0]     cursor_inc;
    logic                  accept;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= '0;
            cap_bytes_reg <= CAP_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ADDR_CAP_BYTES[2])
            begin
                cap_bytes_reg <= pwdata[CAP_BYTE_W-1:0];
            end
            else
            begin
                sync_word_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == ADDR_CAP_BYTES[2])
        begin
            prdata = {{(WORD_W-CAP_BYTE_W){1'b0}}, cap_bytes_reg};
        end
        else
        begin
            prdata = sync_word_reg;
        end
    end

    assign cap_words  = CAP_WORD_W'(({1'b0, cap_bytes_reg} + 19'd3) >> 2);
    assign cursor_inc = cursor_reg + 32'd1;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        sum_next      = sum_reg;
        expected_next = expected_reg;
        st_valid_next = 1'b0;
        st_index_next = '0;
        st_word_next  = '0;
        err_next      = 1'b0;
        bytes_next    = '0;
        unique case (state_reg)
            ST_WAIT_LEN:
            begin
                expected_next = in_ch.word_in;
                state_next    = ST_PAYLOAD;
            end
            ST_PAYLOAD:
            begin
                if (cursor_reg < {{(WORD_W-CAP_WORD_W){1'b0}}, cap_words})
                begin
                    st_valid_next = 1'b1;
                    st_index_next = cursor_reg[INDEX_W-1:0];
                    st_word_next  = in_ch.word_in;
                end
                sum_next    = sum_reg + in_ch.word_in;
                cursor_next = cursor_inc;
                if (cursor_inc >= expected_reg)
                begin
                    state_next = ST_WAIT_SUM;
                end
            end
            ST_WAIT_SUM:
            begin
                if (in_ch.word_in != sum_reg)
                begin
                    err_next   = 1'b1;
                    state_next = ST_WAIT_SYNC;
                end
                else
                begin
                    state_next = ST_COMPLETE;
                    bytes_next = {cursor_reg[WORD_W-3:0], 2'b00};
                end
            end
            default:
            begin
                if (in_ch.word_in == sync_word_reg)
                begin
                    cursor_next = '0;
                    sum_next    = '0;
                    state_next  = ST_WAIT_LEN;
                end
                else
                begin
                    state_next = ST_WAIT_SYNC;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT_SYNC;
            cursor_reg    <= '0;
            sum_reg       <= '0;
            expected_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg    <= state_next;
                cursor_reg   <= cursor_next;
                sum_reg      <= sum_next;
                expected_reg <= expected_next;
            end
            if (in_ch.ready)
            begin
                out_valid_reg <= in_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= state_next;
            st_valid_reg <= st_valid_next;
            st_index_reg <= st_index_next;
            st_word_reg  <= st_word_next;
            err_reg      <= err_next;
            bytes_reg    <= bytes_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.parse_status   = status_reg;
    assign out_ch.store_valid    = st_valid_reg;
    assign out_ch.store_index    = st_index_reg;
    assign out_ch.store_word     = st_word_reg;
    assign out_ch.checksum_error = err_reg;
    assign out_ch.message_bytes  = bytes_reg;

endmodule
